[hw/rtl/sha256_stream_hasher_top_macros.svh]
// Assertion macros for the SHA-256 stream hasher.
// Included by the modules that carry concurrent assertions.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Implication checked on every rising clock edge, disabled while in reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sha_pkg.sv]
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic       store;      // write byte_val into the block buffer
        logic [7:0] byte_val;
        logic       load_init;  // restore initial hash words and clear count
        logic       add_bits;   // count eight more message bits
        logic       snap_len;   // latch bit count for padding
        logic       start;      // load working vars from hash words
        logic       round;      // run one round
        logic       update;     // fold working vars into hash words
    } t_cmd;

    typedef logic [31:0] t_word;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word k_const(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/sha_datapath.sv]
// SHA-256 datapath: schedule window (also holds the incoming block), round logic,
// hash words. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_cmd      i_cmd,
    input  logic [5:0]         i_idx,      // byte index on store, round on round
    input  logic [2:0]         i_word_sel,
    output logic [63:0]        o_len,
    output sha_pkg::t_word     o_word
);

    sha_pkg::t_word r_w   [16];
    sha_pkg::t_word r_h   [8];
    sha_pkg::t_word r_v   [8];
    logic [63:0]    r_bits;
    logic [63:0]    r_len;

    sha_pkg::t_word w_cur, s0, s1, w_new, ep0, ep1, ch, maj, t1, t2;

    // Round i uses window slot 0; the window shifts each round.
    assign w_cur = r_w[0];
    assign s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]}
              ^ (r_w[1] >> 3);
    assign s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
              ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign ep1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
               ^ {r_v[4][24:0], r_v[4][31:25]};
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1  = r_v[7] + ep1 + ch + sha_pkg::k_const(i_idx) + w_cur;
    assign ep0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
               ^ {r_v[0][21:0], r_v[0][31:22]};
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2  = ep0 + maj;

    // Message bytes land big-endian straight in the window; all 64 are
    // rewritten before each compression.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (i_idx[1:0])
                2'd0: r_w[i_idx[5:2]][31:24] <= i_cmd.byte_val;
                2'd1: r_w[i_idx[5:2]][23:16] <= i_cmd.byte_val;
                2'd2: r_w[i_idx[5:2]][15:8]  <= i_cmd.byte_val;
                default: r_w[i_idx[5:2]][7:0] <= i_cmd.byte_val;
            endcase
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::INIT_H[i];
            end
            r_bits <= '0;
        end else begin
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.add_bits) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap_len) begin
            r_len <= r_bits;
        end
    end

    assign o_len  = r_len;
    assign o_word = r_h[i_word_sel];

endmodule

[hw/rtl/sha_ctrl.sv]
// SHA-256 controller: byte intake, padding sequence, rounds and digest output.
// Depends on sha_pkg and the macros header.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_top_macros.svh"

module sha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_mode,
    input  logic [7:0]     i_byte,
    input  logic [63:0]    i_len,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_word_sel,
    output logic           o_last,
    output sha_pkg::t_cmd  o_cmd,
    output logic [5:0]     o_idx
);

    sha_pkg::t_state r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_rnd, n_rnd;
    logic       r_fin, n_fin;    // finish in progress (padding and digest output)
    logic       r_lenph, n_lenph; // length bytes reached
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] pad_byte;

    wire in_xfer  = i_in_valid && o_in_ready;
    wire out_xfer = o_out_valid && i_out_ready;

    always_comb begin
        case (r_cnt)
            3'd0: pad_byte = i_len[63:56];
            3'd1: pad_byte = i_len[55:48];
            3'd2: pad_byte = i_len[47:40];
            3'd3: pad_byte = i_len[39:32];
            3'd4: pad_byte = i_len[31:24];
            3'd5: pad_byte = i_len[23:16];
            3'd6: pad_byte = i_len[15:8];
            3'd7: pad_byte = i_len[7:0];
            default: pad_byte = '0;
        endcase
        if (!r_lenph) begin
            pad_byte = (r_cnt == 3'd0) ? sha_pkg::PAD_BYTE : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_IDLE;
            r_fill  <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_lenph <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rnd   <= n_rnd;
            r_fin   <= n_fin;
            r_lenph <= n_lenph;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and counters.
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rnd   = r_rnd;
        n_fin   = r_fin;
        n_lenph = r_lenph;
        n_cnt   = r_cnt;
        case (r_state)
            sha_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_mode) begin
                        n_fin   = 1'b1;
                        n_lenph = 1'b0;
                        n_cnt   = '0;
                        n_state = sha_pkg::ST_PAD;
                    end else begin
                        n_fill = r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            n_state = sha_pkg::ST_EXPAND;
                        end
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                n_fill = r_fill + 6'd1;
                if (r_lenph) begin
                    n_cnt = r_cnt + 3'd1;
                end else if (n_fill == sha_pkg::LEN_POS) begin
                    n_lenph = 1'b1;
                    n_cnt   = '0;
                end else begin
                    n_cnt = 3'd1;
                end
                if (r_fill == 6'd63) begin
                    n_state = sha_pkg::ST_EXPAND;
                end
            end
            sha_pkg::ST_EXPAND: begin
                n_rnd   = '0;
                n_state = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = sha_pkg::ST_UPDATE;
                end
            end
            sha_pkg::ST_UPDATE: begin
                if (!r_fin) begin
                    n_state = sha_pkg::ST_IDLE;
                end else if (r_lenph) begin
                    n_cnt   = '0;
                    n_state = sha_pkg::ST_OUT;
                end else begin
                    n_state = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_OUT: begin
                if (out_xfer) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_fin   = 1'b0;
                        n_lenph = 1'b0;
                        n_fill  = '0;
                        n_state = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd       = '0;
        o_idx       = r_fill;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            sha_pkg::ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.store      = in_xfer && !i_mode;
                o_cmd.byte_val   = i_byte;
                o_cmd.add_bits   = in_xfer && !i_mode;
                o_cmd.snap_len   = in_xfer && i_mode;
            end
            sha_pkg::ST_PAD: begin
                o_cmd.store    = 1'b1;
                o_cmd.byte_val = pad_byte;
            end
            sha_pkg::ST_EXPAND: o_cmd.start = 1'b1;
            sha_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                o_idx       = r_rnd;
            end
            sha_pkg::ST_UPDATE: o_cmd.update = 1'b1;
            sha_pkg::ST_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.load_init = out_xfer && (r_cnt == 3'd7);
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_word_sel = r_cnt;
    assign o_last     = (r_cnt == 3'd7);

    `SHA_ASSERT_IMP(a_out_only_fin, i_clk, i_rst_n, o_out_valid, r_fin && r_lenph,
        "digest shown outside finish")
    `SHA_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, !o_out_valid,
        "input and output active together")
    `SHA_ASSERT_NXT(a_round_end, i_clk, i_rst_n,
        (r_state == sha_pkg::ST_ROUND) && (r_rnd == 6'd63),
        r_state == sha_pkg::ST_UPDATE, "round count overrun")

endmodule

[hw/rtl/sha256_stream_hasher_top.sv]
// Channel   | Dir | Payload
// s_axis    | in  | tdata[7:0] data byte, tuser[0] finish
// m_axis    | out | tdata[31:0] digest word, tuser[2:0] word index, tlast last word
// Data bytes are taken only while idle; each 64th byte starts a compression (load,
// 64 rounds, hash update) on the single shared round unit, and input is held off until
// it ends. A finish pads through 1 to 2 blocks, one pad byte at a time, then gives eight words.
// Synchronous active-low reset restores the initial hash; output stalls hold.
// Top level of the SHA-256 stream hasher; depends on sha_pkg, sha_ctrl, sha_datapath.
`timescale 1ns / 1ps

module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha_pkg::t_cmd cmd;
    logic [5:0]    idx;
    logic [2:0]    word_sel;
    logic [63:0]   len;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_len       (len),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_word_sel  (word_sel),
        .o_last      (m_axis_tlast),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    sha_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_idx      (idx),
        .i_word_sel (word_sel),
        .o_len      (len),
        .o_word     (m_axis_tdata)
    );

    assign m_axis_tuser = word_sel;

endmodule
